### hdl/u16u8_pkg.sv
// types and constants shared by the utf-16 to utf-8 transcoder
// depends on nothing; every module of the block imports it
package u16u8_pkg;

	// result kinds
	localparam logic [1:0] KIND_DATA  = 2'd0;
	localparam logic [1:0] KIND_DONE  = 2'd1;
	localparam logic [1:0] KIND_ERROR = 2'd2;

	// error codes
	localparam logic [1:0] ERR_NONE          = 2'd0;
	localparam logic [1:0] ERR_NOT_TERMINATED = 2'd1;
	localparam logic [1:0] ERR_TRUNCATED     = 2'd2;
	localparam logic [1:0] ERR_BAD_SURROGATE = 2'd3;

	// surrogate prefixes (upper six bits of a code unit)
	localparam logic [5:0] HIGH_SURR_PREFIX = 6'b110110;
	localparam logic [5:0] LOW_SURR_PREFIX  = 6'b110111;

	// job queue between front and back
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	typedef struct packed {
		logic [15:0] code_unit;
		logic        final_unit;
	} unit_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic [1:0] kind;
		logic [1:0] error_code;
		logic       run_end;
	} result_t;

	// one job: up to four bytes, or a single status result
	typedef struct packed {
		logic [3:0][7:0] bytes;
		logic [1:0]      last;
		logic [1:0]      kind;
		logic [1:0]      error_code;
	} job_t;

endpackage

### hdl/u16u8_front.sv
// front end: accepts code units, tracks surrogate and drop state, builds jobs
// depends on u16u8_pkg
module u16u8_front import u16u8_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  unit_valid,
	output logic  unit_stall,
	input  unit_t unit,
	input  logic  queue_full,
	output logic  push,
	output job_t  job
);

	logic [9:0] high_half_q;
	logic       half_pending_q;
	logic       dropping_q;

	logic       accept;
	logic       is_high;
	logic       is_low;
	logic [20:0] cp;
	logic [20:0] pair_cp;
	job_t       enc_job;

	logic [9:0] high_half_d;
	logic       half_pending_d;
	logic       dropping_d;

	assign unit_stall = queue_full;
	assign accept     = unit_valid && !queue_full;
	assign is_high    = unit.code_unit[15:10] == HIGH_SURR_PREFIX;
	assign is_low     = unit.code_unit[15:10] == LOW_SURR_PREFIX;

	// 0x10000 + (high << 10) + low offset
	assign pair_cp = {11'(high_half_q) + 11'd64, unit.code_unit[9:0]};
	assign cp      = half_pending_q ? pair_cp : {5'd0, unit.code_unit};

	// utf-8 encoding of cp
	always_comb begin
		enc_job            = '0;
		enc_job.kind       = KIND_DATA;
		enc_job.error_code = ERR_NONE;
		if (cp <= 21'h7f) begin
			enc_job.bytes[0] = cp[7:0];
			enc_job.last     = 2'd0;
		end else if (cp <= 21'h7ff) begin
			enc_job.bytes[0] = {3'b110, cp[10:6]};
			enc_job.bytes[1] = {2'b10, cp[5:0]};
			enc_job.last     = 2'd1;
		end else if (cp <= 21'hffff) begin
			enc_job.bytes[0] = {4'b1110, cp[15:12]};
			enc_job.bytes[1] = {2'b10, cp[11:6]};
			enc_job.bytes[2] = {2'b10, cp[5:0]};
			enc_job.last     = 2'd2;
		end else begin
			enc_job.bytes[0] = {5'b11110, cp[20:18]};
			enc_job.bytes[1] = {2'b10, cp[17:12]};
			enc_job.bytes[2] = {2'b10, cp[11:6]};
			enc_job.bytes[3] = {2'b10, cp[5:0]};
			enc_job.last     = 2'd3;
		end
	end

	// classification and next state
	always_comb begin
		high_half_d    = high_half_q;
		half_pending_d = half_pending_q;
		dropping_d     = dropping_q;
		push           = 1'b0;
		job            = '0;
		if (accept) begin
			if (unit.final_unit) begin
				high_half_d    = '0;
				half_pending_d = 1'b0;
				dropping_d     = 1'b0;
				if (!dropping_q) begin
					push = 1'b1;
					if (half_pending_q) begin
						job.kind       = KIND_ERROR;
						job.error_code = ERR_TRUNCATED;
					end else if (unit.code_unit != 16'd0) begin
						job.kind       = KIND_ERROR;
						job.error_code = ERR_NOT_TERMINATED;
					end else begin
						job.kind       = KIND_DONE;
					end
				end
			end else if (!dropping_q) begin
				if (half_pending_q) begin
					half_pending_d = 1'b0;
					high_half_d    = '0;
					push           = 1'b1;
					if (is_low) begin
						job = enc_job;
					end else begin
						dropping_d     = 1'b1;
						job.kind       = KIND_ERROR;
						job.error_code = ERR_BAD_SURROGATE;
					end
				end else if (is_high) begin
					high_half_d    = unit.code_unit[9:0];
					half_pending_d = 1'b1;
				end else if (is_low) begin
					dropping_d     = 1'b1;
					push           = 1'b1;
					job.kind       = KIND_ERROR;
					job.error_code = ERR_BAD_SURROGATE;
				end else begin
					push = 1'b1;
					job  = enc_job;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			high_half_q    <= '0;
			half_pending_q <= 1'b0;
			dropping_q     <= 1'b0;
		end else begin
			high_half_q    <= high_half_d;
			half_pending_q <= half_pending_d;
			dropping_q     <= dropping_d;
		end
	end

endmodule

### hdl/u16u8_queue.sv
// short job queue between front and back
// depends on u16u8_pkg
module u16u8_queue import u16u8_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_job,
	input  logic pop,
	output job_t head,
	output logic full,
	output logic empty
);

	job_t              mem [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	logic do_push;
	logic do_pop;

	assign full    = count_q == QCNT_W'(QUEUE_DEPTH);
	assign empty   = count_q == '0;
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign head    = mem[rd_ptr_q];

	function automatic logic [QPTR_W-1:0] next_ptr(input logic [QPTR_W-1:0] p);
		logic [QPTR_W-1:0] r;
		r = (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
		return r;
	endfunction

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (do_pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			unique case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

### hdl/u16u8_back.sv
// back end: serializes queued jobs into one result per cycle while result_stall is low
// depends on u16u8_pkg
module u16u8_back import u16u8_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  job_t    head,
	input  logic    empty,
	output logic    pop,
	output logic    result_valid,
	input  logic    result_stall,
	output result_t result
);

	job_t       job_q;
	logic [1:0] idx_q;
	logic       busy_q;
	logic       result_valid_q;
	result_t    result_q;

	logic out_free;
	logic emit;
	logic is_last;

	assign out_free = !result_valid_q || !result_stall;
	assign emit     = busy_q && out_free;
	assign is_last  = idx_q == job_q.last;
	assign pop      = (!busy_q || (emit && is_last)) && !empty;

	assign result_valid = result_valid_q;
	assign result       = result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q         <= 1'b0;
			idx_q          <= '0;
			result_valid_q <= 1'b0;
		end else begin
			if (emit) begin
				result_valid_q <= 1'b1;
			end else if (out_free) begin
				result_valid_q <= 1'b0;
			end
			if (pop) begin
				busy_q <= 1'b1;
				idx_q  <= '0;
			end else if (emit && is_last) begin
				busy_q <= 1'b0;
			end else if (emit) begin
				idx_q  <= idx_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			job_q <= head;
		end
		if (emit) begin
			result_q.out_byte   <= job_q.bytes[idx_q];
			result_q.kind       <= job_q.kind;
			result_q.error_code <= job_q.error_code;
			result_q.run_end    <= is_last;
		end
	end

	// status results are single and carry no byte
	a_status_single: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && job_q.kind != KIND_DATA) |-> (is_last && idx_q == 2'd0))
		else $error("status job spans more than one result");

	a_status_zero_byte: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && job_q.kind != KIND_DATA) |=> (result_q.out_byte == 8'd0))
		else $error("status result carries a nonzero byte");

	// a job is only replaced once its last byte has gone out
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && busy_q) |-> (emit && is_last))
		else $error("job overwritten before completion");

	// data results only carry error code none
	a_data_no_code: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && job_q.kind == KIND_DATA) |-> (job_q.error_code == ERR_NONE))
		else $error("data job with error code");

endmodule

### hdl/utf16_to_utf8_transcoder_top.sv
// top level of the utf-16 to utf-8 transcoder
// depends on u16u8_pkg, u16u8_front, u16u8_queue, u16u8_back
//
// usage
//   unit channel: one utf-16 code unit per transfer (unit_valid/unit_stall),
//     final_unit marks the string's terminator, which must be zero
//   result channel: one result per transfer (result_valid/result_stall):
//     a utf-8 data byte, or a status (string done or error with code);
//     run_end flags the last result caused by one code unit
//   a high surrogate gives no result by itself; its pair gives four bytes
//   after an error one error result goes out and units are dropped up to
//     and including the final unit
// timing
//   when the block is idle the first result of a unit passes through the job
//     queue, the job register and the output register
//   the result port moves one result per cycle while result_stall is low;
//     a unit gives 1 to 3 results in the basic plane, 4 for a pair; the byte
//     serializer in the back end sets this rate
//   units that give no result push no job into the queue
// stall and reset
//   a stalled result holds in the output register; the two-entry job queue
//     keeps taking units until it fills, then unit_stall rises
//   reset clears surrogate/drop state, the queue and the output valid
module utf16_to_utf8_transcoder_top import u16u8_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    unit_valid,
	output logic    unit_stall,
	input  unit_t   unit,
	output logic    result_valid,
	input  logic    result_stall,
	output result_t result
);

	// front to queue
	logic push;
	job_t push_job;
	logic queue_full;

	// queue to back
	job_t head;
	logic empty;
	logic pop;

	// classifies units and keeps surrogate state
	u16u8_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.unit_valid (unit_valid),
		.unit_stall (unit_stall),
		.unit       (unit),
		.queue_full (queue_full),
		.push       (push),
		.job        (push_job)
	);

	// decouples front and back
	u16u8_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.head     (head),
		.full     (queue_full),
		.empty    (empty)
	);

	// one result transfer per cycle while result_stall is low
	u16u8_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.empty        (empty),
		.pop          (pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule

### test/utf16_to_utf8_transcoder_top_tb.sv
// self-checking testbench for utf16_to_utf8_transcoder_top
// depends on u16u8_pkg and the transcoder rtl; predicts every utf-8 byte and status result
`timescale 1ns / 100ps

module utf16_to_utf8_transcoder_top_tb import u16u8_pkg::*;;

	localparam int WATCHDOG_LIMIT = 2000;  // cycles with no transfer on either side
	localparam int SETTLE_CYCLES  = 8;     // covers the path through the queue, the job register and the output register
	localparam int LONG_HOLD      = 80;    // long result stall, forces unit_stall
	localparam int PHASE_UNITS    = 40;    // minimum random units per idling phase

	logic    clk          = 1'b0;
	logic    arst_n       = 1'b0;
	logic    unit_valid   = 1'b0;
	logic    unit_stall;
	unit_t   unit         = '0;
	logic    result_valid;
	logic    result_stall = 1'b0;
	result_t result;

	// stimulus and scoreboard storage
	unit_t   pending_units[$];
	result_t expected_utf8[$];
	int      units_queued  = 0;
	int      mismatches    = 0;
	int      quiet_cycles  = 0;

	// idling knobs, percent of cycles
	int      send_idle_pct = 36;
	int      recv_idle_pct = 67;
	bit      send_pause    = 1'b0;

	// long result hold, requested by the stimulus, counted by the receiver
	int      hold_requests = 0;
	int      hold_served   = 0;
	int      hold_left     = 0;

	// unit transfer seen at the last rising edge, read by the driver on the falling edge
	logic    unit_fire     = 1'b0;

	// predictor state
	logic [9:0] held_high  = '0;
	logic       high_held  = 1'b0;
	logic       skipping   = 1'b0;

	utf16_to_utf8_transcoder_top u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.unit_valid   (unit_valid),
		.unit_stall   (unit_stall),
		.unit         (unit),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic result_t data_res(logic [7:0] b);
		result_t r;
		r = '0;
		r.out_byte = b;
		r.kind = KIND_DATA;
		r.error_code = ERR_NONE;
		return r;
	endfunction

	function automatic result_t status_res(logic [1:0] k, logic [1:0] code);
		result_t r;
		r = '0;
		r.kind = k;
		r.error_code = code;
		return r;
	endfunction

	// append one predicted result to the scoreboard
	task automatic queue_result(result_t r);
		expected_utf8.insert(expected_utf8.size(), r);
	endtask

	// predict the results of one accepted code unit and queue them
	task automatic transcode_unit(unit_t cu_in);
		int          first;
		logic [20:0] cp;
		bit          do_encode;
		first = expected_utf8.size();
		do_encode = 1'b0;
		cp = '0;
		if (cu_in.final_unit) begin
			// a final unit while skipping just closes the string quietly
			if (!skipping) begin
				if (high_held)
					queue_result(status_res(KIND_ERROR, ERR_TRUNCATED));
				else if (cu_in.code_unit != 16'h0000)
					queue_result(status_res(KIND_ERROR, ERR_NOT_TERMINATED));
				else
					queue_result(status_res(KIND_DONE, ERR_NONE));
			end
			held_high = '0;
			high_held = 1'b0;
			skipping  = 1'b0;
		end else if (!skipping) begin
			if (high_held) begin
				high_held = 1'b0;
				if (cu_in.code_unit[15:10] == LOW_SURR_PREFIX) begin
					cp = 21'h10000 + {held_high, cu_in.code_unit[9:0]};
					do_encode = 1'b1;
				end else begin
					// second half of the pair is not a low surrogate
					skipping = 1'b1;
					queue_result(status_res(KIND_ERROR, ERR_BAD_SURROGATE));
				end
				held_high = '0;
			end else if (cu_in.code_unit[15:10] == HIGH_SURR_PREFIX) begin
				held_high = cu_in.code_unit[9:0];
				high_held = 1'b1;
			end else if (cu_in.code_unit[15:10] == LOW_SURR_PREFIX) begin
				// lone low surrogate
				skipping = 1'b1;
				queue_result(status_res(KIND_ERROR, ERR_BAD_SURROGATE));
			end else begin
				cp = {5'd0, cu_in.code_unit};
				do_encode = 1'b1;
			end
		end
		if (do_encode) begin
			if (cp <= 21'h7f) begin
				queue_result(data_res(cp[7:0]));
			end else if (cp <= 21'h7ff) begin
				queue_result(data_res({3'b110, cp[10:6]}));
				queue_result(data_res({2'b10, cp[5:0]}));
			end else if (cp <= 21'hffff) begin
				queue_result(data_res({4'b1110, cp[15:12]}));
				queue_result(data_res({2'b10, cp[11:6]}));
				queue_result(data_res({2'b10, cp[5:0]}));
			end else begin
				queue_result(data_res({5'b11110, cp[20:18]}));
				queue_result(data_res({2'b10, cp[17:12]}));
				queue_result(data_res({2'b10, cp[11:6]}));
				queue_result(data_res({2'b10, cp[5:0]}));
			end
		end
		if (expected_utf8.size() > first)
			expected_utf8[expected_utf8.size() - 1].run_end = 1'b1;
	endtask

	// driver: new unit on the falling edge once the current one has gone
	always @(negedge clk) begin
		if (arst_n) begin
			if (!unit_valid || unit_fire) begin
				if (pending_units.size() > 0 && !send_pause &&
				    $urandom_range(0, 99) >= send_idle_pct) begin
					unit       <= pending_units.pop_front();
					unit_valid <= 1'b1;
				end else begin
					unit_valid <= 1'b0;
				end
			end
		end
	end

	// receiver: random stall, or a long hold when one is requested
	always @(negedge clk) begin
		if (hold_served != hold_requests) begin
			hold_served  <= hold_requests;
			hold_left    <= LONG_HOLD;
			result_stall <= 1'b1;
		end else if (hold_left > 0) begin
			hold_left    <= hold_left - 1;
			result_stall <= 1'b1;
		end else begin
			result_stall <= ($urandom_range(0, 99) < recv_idle_pct);
		end
	end

	// monitor: predict on each unit transfer, check each result transfer
	always @(posedge clk) begin
		result_t want;
		unit_fire <= arst_n && unit_valid && !unit_stall;
		if (arst_n) begin
			if (unit_valid && !unit_stall)
				transcode_unit(unit);
			if (result_valid && !result_stall) begin
				if (expected_utf8.size() == 0) begin
					$error("unexpected result: out_byte %0h kind %0d error_code %0d run_end %0b",
					       result.out_byte, result.kind, result.error_code, result.run_end);
					mismatches++;
				end else begin
					want = expected_utf8.pop_front();
					if (result.out_byte !== want.out_byte) begin
						$error("out_byte: expected %0h, got %0h", want.out_byte, result.out_byte);
						mismatches++;
					end
					if (result.kind !== want.kind) begin
						$error("kind: expected %0d, got %0d", want.kind, result.kind);
						mismatches++;
					end
					if (result.error_code !== want.error_code) begin
						$error("error_code: expected %0d, got %0d",
						       want.error_code, result.error_code);
						mismatches++;
					end
					if (result.run_end !== want.run_end) begin
						$error("run_end: expected %0b, got %0b", want.run_end, result.run_end);
						mismatches++;
					end
				end
			end
		end
	end

	// watchdog: ends a run that has stopped moving
	always @(posedge clk) begin
		if ((unit_valid && !unit_stall) || (result_valid && !result_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic push_unit(logic [15:0] code, logic fin);
		unit_t u;
		u.code_unit  = code;
		u.final_unit = fin;
		pending_units.insert(pending_units.size(), u);
		units_queued++;
	endtask

	// one string: mostly well-formed characters, some broken pieces, then a terminator
	task automatic push_random_string();
		int          len;
		int          pick;
		logic [15:0] cu;
		len = $urandom_range(0, 5);
		for (int i = 0; i < len; i++) begin
			pick = $urandom_range(0, 9);
			case (pick)
				0, 1, 2: begin
					push_unit(16'($urandom_range(16'h0000, 16'h007f)), 1'b0);
				end
				3, 4: begin
					push_unit(16'($urandom_range(16'h0080, 16'h07ff)), 1'b0);
				end
				5, 6: begin
					// three-byte range with the surrogate block skipped
					cu = 16'($urandom_range(16'h0800, 16'hf7ff));
					if (cu >= 16'hd800)
						cu = cu + 16'h0800;
					push_unit(cu, 1'b0);
				end
				7, 8: begin
					push_unit(16'hd800 | 16'($urandom_range(0, 16'h03ff)), 1'b0);
					push_unit(16'hdc00 | 16'($urandom_range(0, 16'h03ff)), 1'b0);
				end
				default: begin
					// noise: any unit, a lone low half, or a high half left hanging
					case ($urandom_range(0, 2))
						0: push_unit(16'($urandom_range(0, 16'hffff)), 1'b0);
						1: push_unit(16'hdc00 | 16'($urandom_range(0, 16'h03ff)), 1'b0);
						default: push_unit(16'hd800 | 16'($urandom_range(0, 16'h03ff)), 1'b0);
					endcase
				end
			endcase
		end
		if ($urandom_range(0, 9) == 0)
			push_unit(16'($urandom_range(0, 16'hffff)), 1'b1);
		else
			push_unit(16'h0000, 1'b1);
	endtask

	// sender pause: nothing new goes in until every expected result is out
	task automatic wait_drained();
		// all queued units sent and the input idle at a sampling edge
		@(posedge clk);
		while (pending_units.size() != 0 || unit_valid)
			@(posedge clk);
		send_pause = 1'b1;
		while (expected_utf8.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		send_pause = 1'b0;
	endtask

	task automatic run_random_phase(int send_pct, int recv_pct, bit long_hold);
		int target;
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		target = units_queued + PHASE_UNITS;
		while (units_queued < target)
			push_random_string();
		if (long_hold) begin
			// sender keeps offering while results are held back, so the job queue fills
			repeat (10) @(negedge clk);
			hold_requests++;
		end
		wait_drained();
	endtask

	initial begin
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// empty string
		push_unit(16'h0000, 1'b1);
		// byte-length boundaries, embedded zero, edges of the surrogate block
		push_unit(16'h0000, 1'b0);
		push_unit(16'h007f, 1'b0);
		push_unit(16'h0080, 1'b0);
		push_unit(16'h07ff, 1'b0);
		push_unit(16'h0800, 1'b0);
		push_unit(16'hd7ff, 1'b0);
		push_unit(16'he000, 1'b0);
		push_unit(16'hffff, 1'b0);
		// lowest and highest supplementary code points
		push_unit(16'hd800, 1'b0);
		push_unit(16'hdc00, 1'b0);
		push_unit(16'hdbff, 1'b0);
		push_unit(16'hdfff, 1'b0);
		push_unit(16'h0000, 1'b1);
		// missing terminator, plain and as a high half
		push_unit(16'h0041, 1'b1);
		push_unit(16'hdbff, 1'b1);
		// truncated pair, with zero and nonzero final units
		push_unit(16'hd800, 1'b0);
		push_unit(16'h0000, 1'b1);
		push_unit(16'hd9ab, 1'b0);
		push_unit(16'hffff, 1'b1);
		// bad low half, then units dropped through the final one
		push_unit(16'hd800, 1'b0);
		push_unit(16'h0041, 1'b0);
		push_unit(16'hdc00, 1'b0);
		push_unit(16'hffff, 1'b1);
		// lone low half, terminator dropped
		push_unit(16'hdfff, 1'b0);
		push_unit(16'h0000, 1'b1);
		wait_drained();

		run_random_phase(36, 67, 1'b1);
		run_random_phase(67, 36, 1'b0);
		run_random_phase(0, 0, 1'b0);

		if (mismatches == 0 && expected_utf8.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

### utf16_to_utf8_transcoder_top.f
hdl/u16u8_pkg.sv
hdl/u16u8_front.sv
hdl/u16u8_queue.sv
hdl/u16u8_back.sv
hdl/utf16_to_utf8_transcoder_top.sv
test/utf16_to_utf8_transcoder_top_tb.sv
